FILE: rtl/core/fdsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fieldbus datagram parser package
// Shared types and constants for the front parser, queue and back emitter.
// ----------------------------------------------------------------------------
package fdsp_pkg;

   localparam int LEN_BITS   = 11;
   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [10:0] MAX_LEN_RESET = 11'h7FF;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [1:0] {
      PH_HDR  = 2'd0,
      PH_DATA = 2'd1,
      PH_WKC  = 2'd2,
      PH_SKIP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DESC    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_LEN   = 2'd2
   } status_type;

   // One result, as carried on the output channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  cmd;
      logic [7:0]  frame_index;
      logic [15:0] station_addr;
      logic [15:0] offset_addr;
      logic [10:0] data_len;
      logic [15:0] irq_word;
      logic [15:0] work_counter;
      logic [7:0]  payload;
      logic [7:0]  dgram_count;
      logic [1:0]  status;
      logic        last_of_run;
   } result_type;

   // Classified work for one input item: up to two results.
   typedef struct packed {
      logic       has_first;
      logic       has_second;
      result_type first;
      result_type second;
   } work_type;

endpackage

FILE: rtl/core/fdsp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one byte of the datagram area.
// ----------------------------------------------------------------------------
interface fdsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_pdu;
   modport source (output valid, output data_byte, output end_of_pdu, input ready);
   modport sink   (input valid, input data_byte, input end_of_pdu, output ready);
endinterface

FILE: rtl/core/fdsp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying one parser result.
// ----------------------------------------------------------------------------
interface fdsp_rsp_if;
   logic                valid;
   logic                ready;
   fdsp_pkg::result_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/fieldbus_datagram_stream_parser_unit.sv
`timescale 1ns / 1ps
// Each accepted item is classified and its results queued for the output.
// Throughput: one item per cycle while the queue has room; a byte giving two
// results holds the output for both, which the four-entry work queue absorbs.
// Reset: synchronous; clears parser state and queue, max_data_len to 2047.
// ----------------------------------------------------------------------------
// Fieldbus datagram stream parser
// Front parser and back emitter joined by a short work queue.
// ----------------------------------------------------------------------------
module fieldbus_datagram_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   fdsp_req_if.sink    req,
   fdsp_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data
);

   logic               [10:0] max_len_ff;
   logic               room;
   logic               take;
   fdsp_pkg::work_type work;

   assign req.ready = room;
   assign take      = req.valid && room;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= fdsp_pkg::MAX_LEN_RESET;
      else if (csr_write_enable) max_len_ff <= csr_write_data;
   end

   fdsp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req.data_byte),
      .end_of_pdu   (req.end_of_pdu),
      .max_data_len (max_len_ff),
      .work         (work)
   );

   fdsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .push     (take && work.has_first),
      .work     (work),
      .has_room (room),
      .rsp      (rsp)
   );

endmodule

FILE: rtl/core/fdsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram parser front end
// Tracks header, data, working-counter and skip phases and classifies each
// item into up to two results.
// ----------------------------------------------------------------------------
module fdsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_pdu,
   input  logic [10:0]           max_data_len,
   output fdsp_pkg::work_type    work
);

   fdsp_pkg::phase_type            phase_ff, phase_in;
   logic [3:0]                     hpos_ff, hpos_in;
   logic [63:0]                    hdr_ff, hdr_in;
   logic [15:0]                    irq_ff, irq_in;
   logic [fdsp_pkg::LEN_BITS-1:0]  rem_ff, rem_in;
   logic [7:0]                     wkcl_ff, wkcl_in;
   logic [fdsp_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                           err_ff, err_in;

   logic [fdsp_pkg::LEN_BITS-1:0] len;
   logic [fdsp_pkg::COUNT_BITS-1:0] cnt_now;
   fdsp_pkg::result_type          pay_r, desc_r, sum_r;
   logic                          pay_v, desc_v;
   fdsp_pkg::status_type          st;

   assign len = fdsp_pkg::LEN_BITS'(hdr_ff[63:48]);

   // Next state and result classification.
   always_comb begin
      phase_in = phase_ff;
      hpos_in  = hpos_ff;
      hdr_in   = hdr_ff;
      irq_in   = irq_ff;
      rem_in   = rem_ff;
      wkcl_in  = wkcl_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      pay_v    = 1'b0;
      desc_v   = 1'b0;
      pay_r    = '0;
      desc_r   = '0;
      sum_r    = '0;
      case (phase_ff)
         fdsp_pkg::PH_HDR: begin
            if (hpos_ff < 4'd8) hdr_in[hpos_ff[2:0]*8 +: 8] = data_byte;
            else if (hpos_ff == 4'd8) irq_in = {8'h00, data_byte};
            else irq_in = {data_byte, irq_ff[7:0]};
            hpos_in = hpos_ff + 4'd1;
            if (hpos_ff == 4'd9) begin
               hpos_in = '0;
               if (32'(len) > 32'(max_data_len)) begin
                  err_in   = 1'b1;
                  phase_in = fdsp_pkg::PH_SKIP;
               end else begin
                  rem_in   = len;
                  phase_in = (len != '0) ? fdsp_pkg::PH_DATA : fdsp_pkg::PH_WKC;
               end
            end
         end
         fdsp_pkg::PH_DATA: begin
            pay_v         = 1'b1;
            pay_r.kind    = fdsp_pkg::KIND_PAYLOAD;
            pay_r.payload = data_byte;
            rem_in        = rem_ff - 1'b1;
            if (rem_ff == fdsp_pkg::LEN_BITS'(1)) begin
               phase_in = fdsp_pkg::PH_WKC;
               hpos_in  = '0;
            end
         end
         fdsp_pkg::PH_WKC: begin
            if (hpos_ff == 4'd0) begin
               wkcl_in = data_byte;
               hpos_in = 4'd1;
            end else begin
               desc_v              = 1'b1;
               desc_r.kind         = fdsp_pkg::KIND_DESC;
               desc_r.cmd          = hdr_ff[7:0];
               desc_r.frame_index  = hdr_ff[15:8];
               desc_r.station_addr = hdr_ff[31:16];
               desc_r.offset_addr  = hdr_ff[47:32];
               desc_r.data_len     = 11'(len);
               desc_r.irq_word     = irq_ff;
               desc_r.work_counter = {data_byte, wkcl_ff};
               desc_r.dgram_count  = 8'(cnt_ff);
               if (cnt_ff != fdsp_pkg::COUNT_MAX) cnt_in = cnt_ff + 1'b1;
               phase_in = fdsp_pkg::PH_HDR;
               hpos_in  = '0;
               hdr_in   = '0;
               irq_in   = '0;
               wkcl_in  = '0;
            end
         end
         default: ;
      endcase

      // PDU end summary uses the post-step state.
      cnt_now = cnt_in;
      if (err_in) st = fdsp_pkg::ST_LEN;
      else if (phase_in != fdsp_pkg::PH_HDR || hpos_in != 4'd0) st = fdsp_pkg::ST_TRUNC;
      else st = fdsp_pkg::ST_OK;
      sum_r.kind        = fdsp_pkg::KIND_SUMMARY;
      sum_r.dgram_count = 8'(cnt_now);
      sum_r.status      = st;
      sum_r.last_of_run = 1'b1;
      if (end_of_pdu) begin
         phase_in = fdsp_pkg::PH_HDR;
         hpos_in  = '0;
         hdr_in   = '0;
         irq_in   = '0;
         rem_in   = '0;
         wkcl_in  = '0;
         cnt_in   = '0;
         err_in   = 1'b0;
      end

      work = '0;
      if (pay_v || desc_v) begin
         work.has_first         = 1'b1;
         work.first             = pay_v ? pay_r : desc_r;
         work.first.last_of_run = !end_of_pdu;
         work.has_second        = end_of_pdu;
         work.second            = sum_r;
      end else if (end_of_pdu) begin
         work.has_first = 1'b1;
         work.first     = sum_r;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fdsp_pkg::PH_HDR;
         hpos_ff  <= '0;
         hdr_ff   <= '0;
         irq_ff   <= '0;
         rem_ff   <= '0;
         wkcl_ff  <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         hdr_ff   <= hdr_in;
         irq_ff   <= irq_in;
         rem_ff   <= rem_in;
         wkcl_ff  <= wkcl_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   // The header position never runs past the last header byte.
   assert property (@(posedge clock) disable iff (reset) hpos_ff <= 4'd9)
      else $error("header position out of range");
   // The skip phase is only entered with an error held.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == fdsp_pkg::PH_SKIP |-> err_ff)
      else $error("skip phase without error");
   // The data phase always has bytes left to take.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == fdsp_pkg::PH_DATA |-> rem_ff != '0)
      else $error("data phase with no bytes left");

endmodule

FILE: rtl/core/fdsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram parser back end
// Work queue and result emitter: each entry gives one or two results.
// ----------------------------------------------------------------------------
module fdsp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fdsp_pkg::work_type work,
   output logic               has_room,
   fdsp_rsp_if.source         rsp
);

   fdsp_pkg::work_type        mem [fdsp_pkg::QUEUE_DEPTH];
   logic [fdsp_pkg::QUEUE_AW-1:0] wp_ff, rp_ff;
   logic [fdsp_pkg::QUEUE_AW:0]   fill_ff, fill_in;
   logic                      sec_ff, sec_in;
   logic                      pop;
   fdsp_pkg::work_type        head;

   assign head     = mem[rp_ff];
   assign has_room = fill_ff < (fdsp_pkg::QUEUE_AW+1)'(fdsp_pkg::QUEUE_DEPTH);
   assign rsp.valid = fill_ff != '0;
   assign rsp.data  = sec_ff ? head.second : head.first;

   // An entry leaves after its last result is taken.
   always_comb begin
      pop    = 1'b0;
      sec_in = sec_ff;
      if (rsp.valid && rsp.ready) begin
         if (!sec_ff && head.has_second) sec_in = 1'b1;
         else begin
            pop    = 1'b1;
            sec_in = 1'b0;
         end
      end
      fill_in = fill_ff + (fdsp_pkg::QUEUE_AW+1)'(push) - (fdsp_pkg::QUEUE_AW+1)'(pop);
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= work;
   end

   // Queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
         sec_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_in;
         sec_ff  <= sec_in;
      end
   end

   // No push into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> has_room)
      else $error("push into full queue");
   // Second result only shown for an entry that has one.
   assert property (@(posedge clock) disable iff (reset)
      sec_ff |-> rsp.valid && head.has_second)
      else $error("second result without entry");
   // Fill never exceeds depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (fdsp_pkg::QUEUE_AW+1)'(fdsp_pkg::QUEUE_DEPTH))
      else $error("queue overfill");

endmodule

FILE: tb/fdsp_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Test stall interface
// The channel interfaces are part of the RTL; this file only holds the
// test-side hold-off for the result channel's ready, kept apart for clarity.
// ----------------------------------------------------------------------------
interface fdsp_tb_stall_if;
   logic hold_off;
   modport source (output hold_off);
   modport sink   (input hold_off);
endinterface

FILE: tb/fieldbus_datagram_stream_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Datagram stream parser test
// Feeds random and directed PDUs through the parser with random idling and
// checks every result against a cycle-free model of the parser kept here.
// ----------------------------------------------------------------------------
module fieldbus_datagram_stream_parser_unit_test;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_pdu;
   } byte_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [10:0] csr_write_data = '0;

   fdsp_req_if req ();
   fdsp_rsp_if rsp ();
   fdsp_tb_stall_if stall ();

   fieldbus_datagram_stream_parser_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req.sink),
      .rsp              (rsp.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser model state.
   logic [10:0]         max_len;
   fdsp_pkg::phase_type ph;
   logic [3:0]          hpos;
   logic [63:0]         hdr;
   logic [15:0]         irq_hold;
   logic [10:0]         remaining;
   logic [7:0]          wkc_low;
   logic [7:0]          dgram_total;
   logic [1:0]          err;

   byte_item_type        bytes_pending[$];
   fdsp_pkg::result_type results_expected[$];
   int  sender_idle = 0;
   int  receiver_stall = 0;
   bit  hold_start = 0;
   bit  failed = 0;
   bit  stimulus_done = 0;
   longint cycle_count = 0;

   task automatic clear_pdu_state();
      ph = fdsp_pkg::PH_HDR; hpos = '0; hdr = '0; irq_hold = '0;
      remaining = '0; wkc_low = '0; dgram_total = '0; err = '0;
   endtask

   // Work out the results one accepted byte causes.
   task automatic predict_parse(input byte_item_type it);
      fdsp_pkg::result_type r;
      fdsp_pkg::result_type outs[$];
      logic [10:0] len;
      case (ph)
         fdsp_pkg::PH_HDR: begin
            if (hpos < 8) hdr[8*hpos +: 8] = it.data_byte;
            else if (hpos == 8) irq_hold = {8'h00, it.data_byte};
            else irq_hold[15:8] = it.data_byte;
            hpos = hpos + 4'd1;
            if (hpos >= 10) begin
               len = hdr[58:48];
               hpos = '0;
               if (len > max_len) begin
                  err = fdsp_pkg::ST_LEN;
                  ph = fdsp_pkg::PH_SKIP;
               end else begin
                  remaining = len;
                  ph = (len != 0) ? fdsp_pkg::PH_DATA : fdsp_pkg::PH_WKC;
               end
            end
         end
         fdsp_pkg::PH_DATA: begin
            r = '0;
            r.kind = fdsp_pkg::KIND_PAYLOAD;
            r.payload = it.data_byte;
            outs.push_back(r);
            remaining = remaining - 11'd1;
            if (remaining == 0) begin
               ph = fdsp_pkg::PH_WKC;
               hpos = '0;
            end
         end
         fdsp_pkg::PH_WKC: begin
            if (hpos == 0) begin
               wkc_low = it.data_byte;
               hpos = 4'd1;
            end else begin
               r = '0;
               r.kind = fdsp_pkg::KIND_DESC;
               r.cmd = hdr[7:0];
               r.frame_index = hdr[15:8];
               r.station_addr = hdr[31:16];
               r.offset_addr = hdr[47:32];
               r.data_len = hdr[58:48];
               r.irq_word = irq_hold;
               r.work_counter = {it.data_byte, wkc_low};
               r.dgram_count = dgram_total;
               outs.push_back(r);
               if (dgram_total != fdsp_pkg::COUNT_MAX) dgram_total = dgram_total + 8'd1;
               ph = fdsp_pkg::PH_HDR; hpos = '0; hdr = '0; irq_hold = '0; wkc_low = '0;
            end
         end
         default: ;
      endcase
      if (it.end_of_pdu) begin
         r = '0;
         r.kind = fdsp_pkg::KIND_SUMMARY;
         r.dgram_count = dgram_total;
         if (err != 0) r.status = err;
         else if (ph != fdsp_pkg::PH_HDR || hpos != 0) r.status = fdsp_pkg::ST_TRUNC;
         else r.status = fdsp_pkg::ST_OK;
         outs.push_back(r);
         clear_pdu_state();
      end
      if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
      foreach (outs[i]) results_expected.push_back(outs[i]);
   endtask

   // Driver: offers queued bytes, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data_byte <= '0;
         req.end_of_pdu <= 1'b0;
      end else begin
         if (req.valid && req.ready) predict_parse({req.data_byte, req.end_of_pdu});
         if ((!req.valid || req.ready)) begin
            if (bytes_pending.size() > 0 && $urandom_range(99) >= sender_idle) begin
               req.valid <= 1'b1;
               {req.data_byte, req.end_of_pdu} <= bytes_pending.pop_front();
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted in cycles.
   initial begin
      stall.hold_off = 1'b0;
      wait (hold_start);
      @(posedge clock);
      stall.hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      stall.hold_off <= 1'b0;
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      fdsp_pkg::result_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (results_expected.size() == 0) begin
               $error("unexpected result kind=%0d", rsp.data.kind);
               failed = 1;
            end else begin
               want = results_expected.pop_front();
               if (rsp.data.kind != want.kind) begin
                  $error("kind exp %0d got %0d", want.kind, rsp.data.kind); failed = 1; end
               if (rsp.data.cmd != want.cmd) begin
                  $error("cmd exp %0h got %0h", want.cmd, rsp.data.cmd); failed = 1; end
               if (rsp.data.frame_index != want.frame_index) begin
                  $error("frame_index exp %0h got %0h", want.frame_index,
                         rsp.data.frame_index); failed = 1; end
               if (rsp.data.station_addr != want.station_addr) begin
                  $error("station_addr exp %0h got %0h", want.station_addr,
                         rsp.data.station_addr); failed = 1; end
               if (rsp.data.offset_addr != want.offset_addr) begin
                  $error("offset_addr exp %0h got %0h", want.offset_addr,
                         rsp.data.offset_addr); failed = 1; end
               if (rsp.data.data_len != want.data_len) begin
                  $error("data_len exp %0d got %0d", want.data_len, rsp.data.data_len);
                  failed = 1; end
               if (rsp.data.irq_word != want.irq_word) begin
                  $error("irq_word exp %0h got %0h", want.irq_word, rsp.data.irq_word);
                  failed = 1; end
               if (rsp.data.work_counter != want.work_counter) begin
                  $error("work_counter exp %0h got %0h", want.work_counter,
                         rsp.data.work_counter); failed = 1; end
               if (rsp.data.payload != want.payload) begin
                  $error("payload exp %0h got %0h", want.payload, rsp.data.payload);
                  failed = 1; end
               if (rsp.data.dgram_count != want.dgram_count) begin
                  $error("dgram_count exp %0d got %0d", want.dgram_count,
                         rsp.data.dgram_count); failed = 1; end
               if (rsp.data.status != want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp.data.status);
                  failed = 1; end
               if (rsp.data.last_of_run != want.last_of_run) begin
                  $error("last_of_run exp %0d got %0d", want.last_of_run,
                         rsp.data.last_of_run); failed = 1; end
            end
         end
         if (stall.hold_off) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= receiver_stall);
         end
      end
   end

   // Queue one datagram with random content; the length sets data bytes.
   task automatic add_datagram(input int len, input bit eop_last);
      logic [15:0] lw;
      lw = {5'($urandom_range(31)), len[10:0]};
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({lw[7:0], 1'b0});
      bytes_pending.push_back({lw[15:8], 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      for (int i = 0; i < len; i++) bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), 1'b0});
      bytes_pending.push_back({8'($urandom), eop_last});
   endtask

   // Ends the PDU that starts at entry first: cut it at a random point,
   // or add a lone end byte.
   task automatic end_pdu_cut(input int first);
      int k;
      if (bytes_pending.size() > first && $urandom_range(1)) begin
         k = $urandom_range(bytes_pending.size() - 1, first);
         while (bytes_pending.size() > k + 1) void'(bytes_pending.pop_back());
         bytes_pending[k].end_of_pdu = 1'b1;
      end else begin
         bytes_pending.push_back({8'($urandom), 1'b1});
      end
   endtask

   task automatic wait_drained();
      while (bytes_pending.size() > 0 || req.valid || results_expected.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [10:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      max_len = value;
   endtask

   // Random PDUs: mostly well formed, some cut short.
   task automatic random_pdus(input int n_bytes);
      int start_count;
      int nd;
      int pdu_start;
      start_count = bytes_pending.size();
      while (bytes_pending.size() - start_count < n_bytes) begin
         nd = $urandom_range(1, 4);
         pdu_start = bytes_pending.size();
         for (int d = 0; d < nd; d++)
            add_datagram(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6),
                         d == nd - 1 && $urandom_range(3) != 0);
         if (!bytes_pending[bytes_pending.size()-1].end_of_pdu) end_pdu_cut(pdu_start);
      end
   endtask

   initial begin
      max_len = fdsp_pkg::MAX_LEN_RESET;
      clear_pdu_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero-length datagram, all-ones header with a short length word,
      // lone end byte, truncated datagram and a length error.
      add_datagram(0, 1'b0);
      bytes_pending.push_back({8'hFF, 1'b0});
      repeat (5) bytes_pending.push_back({8'hFF, 1'b0});
      bytes_pending.push_back({8'h02, 1'b0});
      bytes_pending.push_back({8'hF8, 1'b0});
      repeat (2) bytes_pending.push_back({8'hFF, 1'b0});
      repeat (2) bytes_pending.push_back({8'h00, 1'b0});
      bytes_pending.push_back({8'hFF, 1'b0});
      bytes_pending.push_back({8'hFF, 1'b1});
      bytes_pending.push_back({8'h00, 1'b1});
      wait_drained();
      write_max_len(11'd3);
      add_datagram(4, 1'b1);
      add_datagram(2, 1'b0);
      bytes_pending.push_back({8'h55, 1'b1});
      wait_drained();

      // Phase sweep over limits and idling.
      write_max_len(11'd0);
      random_pdus(60);
      wait_drained();
      write_max_len(11'h7FF);
      random_pdus(180);
      wait_drained();
      sender_idle = 64;
      write_max_len(11'd5);
      random_pdus(150);
      wait_drained();
      sender_idle = 0; receiver_stall = 64;
      write_max_len(11'd2047);
      random_pdus(150);
      wait_drained();
      sender_idle = 11; receiver_stall = 11;
      write_max_len(11'd20);
      // One PDU of many short datagrams.
      for (int d = 0; d < 20; d++) add_datagram(0, d == 19);
      random_pdus(90);
      hold_start = 1;
      wait_drained();
      receiver_stall = 0; sender_idle = 0;
      random_pdus(30);
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (bytes_pending.size() > 0 || req.valid || results_expected.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end
endmodule

FILE: files.f
rtl/core/fdsp_pkg.sv
rtl/core/fdsp_req_if.sv
rtl/core/fdsp_rsp_if.sv
rtl/core/fdsp_front.sv
rtl/core/fdsp_back.sv
rtl/core/fieldbus_datagram_stream_parser_unit.sv
tb/fdsp_tb_if.sv
tb/fieldbus_datagram_stream_parser_unit_test.sv
